// File: rtl/fmp_pkg.sv
// Package for the FLAC metadata parser: phase codes, result kinds, result record.
// No dependencies.
package fmp_pkg;

    typedef enum logic [3:0] {
        PH_MARK, PH_HDR, PH_SINFO, PH_APPID, PH_APPDATA, PH_SEEK, PH_VLEN,
        PH_VDATA, PH_CCOUNT, PH_CLEN, PH_CDATA, PH_SKIP, PH_DONE, PH_HALT
    } t_phase;

    localparam logic [3:0] K_HDR    = 4'd0;
    localparam logic [3:0] K_SINFO  = 4'd1;
    localparam logic [3:0] K_APPID  = 4'd2;
    localparam logic [3:0] K_APPB   = 4'd3;
    localparam logic [3:0] K_SEEK   = 4'd4;
    localparam logic [3:0] K_VLEN   = 4'd5;
    localparam logic [3:0] K_VBYTE  = 4'd6;
    localparam logic [3:0] K_CCOUNT = 4'd7;
    localparam logic [3:0] K_CLEN   = 4'd8;
    localparam logic [3:0] K_CBYTE  = 4'd9;
    localparam logic [3:0] K_END    = 4'd10;
    localparam logic [3:0] K_BADMK  = 4'd11;

    localparam logic [31:0] MAGIC      = 32'h664c6143;
    localparam logic [23:0] SEEK_BYTES = 24'd18;

    typedef struct packed {
        logic [3:0]  kind;
        logic [6:0]  block_kind;
        logic        final_block;
        logic [3:0]  field_number;
        logic [23:0] item_number;
        logic [63:0] field_value;
        logic        last_of_run;
    } t_result;

endpackage

// File: rtl/flac_metadata_parser.sv
// FLAC metadata section parser: top level joining the byte decoder and result queue.
// Depends on fmp_pkg, fmp_front, fmp_queue.
//
// Usage: stream bytes into i_data_byte under i_valid/o_ready, starting with
// the four marker bytes. Each accepted beat yields zero to three result
// records on the o_ side under o_valid/i_ready; o_last_of_run flags the
// final record caused by one byte.
// Throughput: one byte per cycle while o_ready is high. Each record is
// written into the queue as its byte is accepted. The decoder writes up
// to three records into an eight-entry queue; o_ready drops only while
// fewer than three entries are free, so a stalled receiver backs up into
// the byte channel and nothing is lost.
// Reset: synchronous, active low; the parser waits for the marker again
// and the queue empties. A bad marker, or the end of the last block,
// leaves the parser accepting and dropping every further byte.
module flac_metadata_parser
    import fmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_kind,
    output logic [6:0]  o_block_kind,
    output logic        o_final_block,
    output logic [3:0]  o_field_number,
    output logic [23:0] o_item_number,
    output logic [63:0] o_field_value,
    output logic        o_last_of_run
);
    logic       fire;
    logic [1:0] cnt;
    t_result    res0, res1, res2, head;

    assign fire = i_valid && o_ready;

    fmp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_fire(fire), .i_byte(i_data_byte),
        .o_count(cnt), .o_res0(res0), .o_res1(res1), .o_res2(res2)
    );

    fmp_queue #(.DEPTH(8)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fire), .i_count(cnt),
        .i_res0(res0), .i_res1(res1), .i_res2(res2), .o_room(o_ready),
        .o_valid(o_valid), .o_head(head), .i_pop(i_ready)
    );

    assign o_kind         = head.kind;
    assign o_block_kind   = head.block_kind;
    assign o_final_block  = head.final_block;
    assign o_field_number = head.field_number;
    assign o_item_number  = head.item_number;
    assign o_field_value  = head.field_value;
    assign o_last_of_run  = head.last_of_run;

endmodule

// File: rtl/fmp_front.sv
// Front end: decodes one stream byte per beat into up to three result records.
// Depends on fmp_pkg.
module fmp_front
    import fmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output logic [1:0] o_count,
    output t_result    o_res0,
    output t_result    o_res1,
    output t_result    o_res2
);

    t_phase      r_phase, n_phase;
    logic [23:0] r_pos, n_pos;
    logic [23:0] r_brem, n_brem;
    logic [6:0]  r_bkind, n_bkind;
    logic        r_last, n_last;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_inner, n_inner;
    logic [31:0] r_crem, n_crem;
    logic [23:0] r_item, n_item;

    t_result     res [3];
    logic [1:0]  cnt;
    logic [63:0] sh;
    logic [63:0] le;
    logic [23:0] p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MARK;
            r_pos   <= '0;
            r_brem  <= '0;
            r_bkind <= '0;
            r_last  <= 1'b0;
            r_acc   <= '0;
            r_inner <= '0;
            r_crem  <= '0;
            r_item  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_brem  <= n_brem;
            r_bkind <= n_bkind;
            r_last  <= n_last;
            r_acc   <= n_acc;
            r_inner <= n_inner;
            r_crem  <= n_crem;
            r_item  <= n_item;
        end
    end

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_brem = r_brem; n_bkind = r_bkind;
        n_last = r_last; n_acc = r_acc; n_inner = r_inner; n_crem = r_crem;
        n_item = r_item;
        cnt = '0;
        for (int k = 0; k < 3; k++) res[k] = '0;
        sh = {r_acc[55:0], i_byte};
        le = r_acc | ({56'd0, i_byte} << {r_pos[1:0], 3'b000});
        p  = r_pos;
        unique case (r_phase)
            PH_MARK, PH_HDR: begin
                n_acc = {32'd0, sh[31:0]};
                n_pos = r_pos + 24'd1;
                if (r_pos >= 24'd3) begin
                    n_pos = '0;
                    n_acc = '0;
                    if (r_phase == PH_MARK) begin
                        if (sh[31:0] == MAGIC) n_phase = PH_HDR;
                        else begin
                            res[0] = '{K_BADMK, r_bkind, r_last, 4'd0, 24'd0,
                                       {32'd0, sh[31:0]}, 1'b0};
                            cnt = 2'd1;
                            n_phase = PH_HALT;
                        end
                    end else begin
                        n_last  = sh[31];
                        n_bkind = sh[30:24];
                        n_brem  = sh[23:0];
                        n_item  = '0;
                        res[0] = '{K_HDR, sh[30:24], sh[31], 4'd0, 24'd0,
                                   {40'd0, sh[23:0]}, 1'b0};
                        cnt = 2'd1;
                        case (sh[30:24])
                            7'd0:    n_phase = PH_SINFO;
                            7'd2:    n_phase = PH_APPID;
                            7'd3:    n_phase = PH_SEEK;
                            7'd4:    n_phase = PH_VLEN;
                            default: n_phase = PH_SKIP;
                        endcase
                        if (sh[23:0] == 24'd0) begin
                            if (sh[31]) begin
                                res[1] = '{K_END, sh[30:24], sh[31], 4'd0, 24'd0,
                                           64'd0, 1'b0};
                                cnt = 2'd2;
                                n_phase = PH_DONE;
                            end else n_phase = PH_HDR;
                        end
                    end
                end
            end
            PH_DONE, PH_HALT: ;
            default: begin
                unique case (r_phase)
                    PH_SINFO: begin
                        n_acc = sh;
                        n_pos = r_pos + 24'd1;
                        res[0] = '{K_SINFO, r_bkind, r_last, 4'd0, 24'd0, 64'd0, 1'b0};
                        res[1] = res[0];
                        case (p)
                            24'd1: begin res[0].field_value = {48'd0, sh[15:0]};
                                n_acc = '0; cnt = 2'd1; end
                            24'd3: begin res[0].field_number = 4'd1;
                                res[0].field_value = {48'd0, sh[15:0]};
                                n_acc = '0; cnt = 2'd1; end
                            24'd6: begin res[0].field_number = 4'd2;
                                res[0].field_value = {40'd0, sh[23:0]};
                                n_acc = '0; cnt = 2'd1; end
                            24'd9: begin res[0].field_number = 4'd3;
                                res[0].field_value = {40'd0, sh[23:0]};
                                n_acc = '0; cnt = 2'd1; end
                            24'd12: begin res[0].field_number = 4'd4;
                                res[0].field_value = {44'd0, sh[23:4]};
                                res[1].field_number = 4'd5;
                                res[1].field_value = {61'd0, sh[3:1]} + 64'd1;
                                cnt = 2'd2; end
                            24'd13: begin res[0].field_number = 4'd6;
                                res[0].field_value = {59'd0, sh[8:4]} + 64'd1;
                                cnt = 2'd1; end
                            24'd17: begin res[0].field_number = 4'd7;
                                res[0].field_value = {28'd0, sh[35:0]};
                                n_acc = '0; cnt = 2'd1; end
                            24'd25: begin res[0].field_number = 4'd8;
                                res[0].field_value = sh; n_acc = '0; cnt = 2'd1; end
                            24'd33: begin res[0].field_number = 4'd9;
                                res[0].field_value = sh; n_acc = '0; cnt = 2'd1;
                                n_phase = PH_SKIP; end
                            default: ;
                        endcase
                    end
                    PH_APPID: begin
                        n_acc = {32'd0, sh[31:0]};
                        n_pos = r_pos + 24'd1;
                        if (r_pos >= 24'd3) begin
                            res[0] = '{K_APPID, r_bkind, r_last, 4'd0, 24'd0,
                                       {32'd0, sh[31:0]}, 1'b0};
                            cnt = 2'd1; n_acc = '0; n_pos = '0;
                            n_phase = PH_APPDATA;
                        end
                    end
                    PH_APPDATA: begin
                        res[0] = '{K_APPB, r_bkind, r_last, 4'd0, 24'd0,
                                   {56'd0, i_byte}, 1'b0};
                        cnt = 2'd1;
                    end
                    PH_SEEK: begin
                        if (r_pos == 24'd0 && r_brem < SEEK_BYTES) n_phase = PH_SKIP;
                        else begin
                            n_acc = sh;
                            n_pos = r_pos + 24'd1;
                            res[0] = '{K_SEEK, r_bkind, r_last, 4'd0, r_item, sh, 1'b0};
                            if (p == 24'd7) begin cnt = 2'd1; n_acc = '0; end
                            else if (p == 24'd15) begin
                                res[0].field_number = 4'd1; cnt = 2'd1; n_acc = '0;
                            end else if (p == SEEK_BYTES - 24'd1) begin
                                res[0].field_number = 4'd2;
                                res[0].field_value = {48'd0, sh[15:0]};
                                cnt = 2'd1; n_acc = '0; n_pos = '0;
                                n_item = r_item + 24'd1;
                            end
                        end
                    end
                    PH_VLEN, PH_CCOUNT, PH_CLEN: begin
                        n_acc = le;
                        n_pos = r_pos + 24'd1;
                        if (r_pos >= 24'd3) begin
                            n_acc = '0; n_pos = '0; cnt = 2'd1;
                            res[0] = '{K_VLEN, r_bkind, r_last, 4'd0, 24'd0,
                                       {32'd0, le[31:0]}, 1'b0};
                            if (r_phase == PH_VLEN) begin
                                n_inner = le[31:0];
                                n_phase = (le[31:0] != 0) ? PH_VDATA : PH_CCOUNT;
                            end else if (r_phase == PH_CCOUNT) begin
                                res[0].kind = K_CCOUNT;
                                n_crem = le[31:0];
                                n_item = '0;
                                n_phase = (le[31:0] != 0) ? PH_CLEN : PH_SKIP;
                            end else begin
                                res[0].kind = K_CLEN;
                                res[0].item_number = r_item;
                                n_inner = le[31:0];
                                if (le[31:0] != 0) n_phase = PH_CDATA;
                                else begin
                                    n_item = r_item + 24'd1;
                                    n_crem = r_crem - 32'd1;
                                    n_phase = (r_crem != 32'd1) ? PH_CLEN : PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_VDATA: begin
                        res[0] = '{K_VBYTE, r_bkind, r_last, 4'd0, 24'd0,
                                   {56'd0, i_byte}, 1'b0};
                        cnt = 2'd1;
                        n_inner = r_inner - 32'd1;
                        if (r_inner == 32'd1) n_phase = PH_CCOUNT;
                    end
                    PH_CDATA: begin
                        res[0] = '{K_CBYTE, r_bkind, r_last, 4'd0, r_item,
                                   {56'd0, i_byte}, 1'b0};
                        cnt = 2'd1;
                        n_inner = r_inner - 32'd1;
                        if (r_inner == 32'd1) begin
                            n_item = r_item + 24'd1;
                            n_crem = r_crem - 32'd1;
                            n_phase = (r_crem != 32'd1) ? PH_CLEN : PH_SKIP;
                        end
                    end
                    default: ;
                endcase
                n_brem = r_brem - 24'd1;
                if (n_brem == 24'd0) begin
                    n_pos = '0;
                    n_acc = '0;
                    if (r_last) begin
                        res[cnt] = '{K_END, r_bkind, r_last, 4'd0, 24'd0, 64'd0, 1'b0};
                        cnt = cnt + 2'd1;
                        n_phase = PH_DONE;
                    end else n_phase = PH_HDR;
                end
            end
        endcase
        if (cnt != 2'd0) res[cnt - 2'd1].last_of_run = 1'b1;
    end

    assign o_count = cnt;
    assign o_res0  = res[0];
    assign o_res1  = res[1];
    assign o_res2  = res[2];

endmodule

// File: rtl/fmp_queue.sv
// Result queue between the decoder and the output port; takes up to three records a beat.
// Depends on fmp_pkg.
module fmp_queue
    import fmp_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic [1:0] i_count,
    input  t_result i_res0,
    input  t_result i_res1,
    input  t_result i_res2,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head,
    input  logic    i_pop
);
    localparam int AW = $clog2(DEPTH);

    t_result          r_mem [DEPTH];
    logic [AW-1:0]    r_rd, r_wr;
    logic [AW:0]      r_fill, n_fill;
    logic [AW:0]      push_n;
    logic             pop;

    assign pop     = i_pop && (r_fill != '0);
    assign push_n  = i_push ? {{(AW-1){1'b0}}, i_count} : '0;
    assign n_fill  = r_fill + push_n - {{AW{1'b0}}, pop};
    assign o_room  = (r_fill <= (AW+1)'(DEPTH - 3));
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
            if (pop) r_rd <= r_rd + AW'(1);
            r_wr <= r_wr + push_n[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_count > 2'd0) r_mem[r_wr]          <= i_res0;
            if (i_count > 2'd1) r_mem[r_wr + AW'(1)] <= i_res1;
            if (i_count > 2'd2) r_mem[r_wr + AW'(2)] <= i_res2;
        end
    end

endmodule
